// ===== hdl/cbr_pkg.sv =====
package cbr_pkg;

  typedef logic signed [19:0] coord_t;
  typedef logic [11:0]        edge_t;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_RESOLVE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CLAMP,
    ST_SQUARE,
    ST_TEST,
    ST_SQRT,
    ST_DIV,
    ST_MULA,
    ST_UPDB,
    ST_MULC,
    ST_UPDD,
    ST_FIN
  } state_e;

  localparam logic [7:0] RADIUS_RESET = 8'd25;
  localparam int unsigned SQRT_STEPS  = 16;
  localparam int unsigned DIV_STEPS   = 33;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mem_we;
    logic mem_re;
    logic clamp;
    logic square;
    logic sqrt_start;
    logic div_start;
    logic mul_a;
    logic upd_b;
    logic mul_c;
    logic upd_d;
    logic out_load;
  } cbr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic contact;
    logic sqrt_done;
    logic div_done;
  } cbr_sts_t;

  // Divide by 65536, round to nearest, ties away from zero.
  function automatic logic signed [23:0] rnd16(input logic signed [39:0] p);
    logic [39:0] mag;
    logic [40:0] s;
    logic [23:0] m;
    mag = p[39] ? 40'(-p) : 40'(p);
    s   = {1'b0, mag} + 41'd32768;
    m   = s[39:16];
    return p[39] ? 24'(-signed'(m)) : signed'(m);
  endfunction

  function automatic coord_t sat20(input logic signed [23:0] v);
    if (v > 24'sh07FFFF) begin
      return 20'sh7FFFF;
    end else if (v < -24'sh080000) begin
      return -20'sh80000;
    end
    return v[19:0];
  endfunction

endpackage

// ===== hdl/cbr_if.sv =====
interface cbr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  cbr_pkg::edge_t     box_x;
  cbr_pkg::edge_t     box_y;
  cbr_pkg::edge_t     box_width;
  cbr_pkg::edge_t     box_height;
  cbr_pkg::coord_t    pos_x;
  cbr_pkg::coord_t    pos_y;
  cbr_pkg::coord_t    vel_x;
  cbr_pkg::coord_t    vel_y;

  modport source (output valid, command, box_x, box_y, box_width, box_height,
                  pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink   (input valid, command, box_x, box_y, box_width, box_height,
                  pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface cbr_out_if;
  logic               valid;
  logic               ready;
  cbr_pkg::coord_t    new_pos_x;
  cbr_pkg::coord_t    new_pos_y;
  cbr_pkg::coord_t    new_vel_x;
  cbr_pkg::coord_t    new_vel_y;
  logic               on_surface;

  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                  on_surface, input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                  on_surface, output ready);
endinterface

// ===== hdl/cbr_datapath.sv =====
module cbr_datapath #(
  parameter int unsigned MAX_BOXES = 256,
  parameter int unsigned AW        = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  cbr_pkg::cbr_cmd_t cmd_i,
  output cbr_pkg::cbr_sts_t sts_o,
  input  logic [AW-1:0]     addr_i,
  input  cbr_pkg::edge_t    box_x_i,
  input  cbr_pkg::edge_t    box_y_i,
  input  cbr_pkg::edge_t    box_w_i,
  input  cbr_pkg::edge_t    box_h_i,
  input  cbr_pkg::coord_t   pos_x_i,
  input  cbr_pkg::coord_t   pos_y_i,
  input  cbr_pkg::coord_t   vel_x_i,
  input  cbr_pkg::coord_t   vel_y_i,
  output cbr_pkg::coord_t   new_pos_x_o,
  output cbr_pkg::coord_t   new_pos_y_o,
  output cbr_pkg::coord_t   new_vel_x_o,
  output cbr_pkg::coord_t   new_vel_y_o,
  output logic              on_surface_o
);

  logic [47:0] mem_q [MAX_BOXES];
  logic [47:0] rdata_q;
  logic [7:0]  radius_q;

  cbr_pkg::coord_t px_q, py_q, vx_q, vy_q;
  logic            surf_q;
  logic signed [22:0] cx_q, cy_q, dx_q, dy_q;
  logic [44:0] d2_q;
  logic [31:0] r2_q;

  logic [16:0] rq;
  assign rq = {1'b0, radius_q, 8'd0};

  // Clamp and difference.
  logic signed [22:0] left_x, right_x, top_y, bot_y, cx_d, cy_d;
  logic [20:0] rsum_x, rsum_y;
  always_comb begin
    rsum_x  = {1'b0, rdata_q[47:36], 8'd0} + {1'b0, rdata_q[23:12], 8'd0};
    rsum_y  = {1'b0, rdata_q[35:24], 8'd0} + {1'b0, rdata_q[11:0], 8'd0};
    left_x  = signed'({3'd0, rdata_q[47:36], 8'd0});
    top_y   = signed'({3'd0, rdata_q[35:24], 8'd0});
    right_x = signed'({2'd0, rsum_x});
    bot_y   = signed'({2'd0, rsum_y});
    cx_d    = 23'(px_q);
    cy_d    = 23'(py_q);
    if (cx_d < left_x) cx_d = left_x;
    if (cx_d > right_x) cx_d = right_x;
    if (cy_d < top_y) cy_d = top_y;
    if (cy_d > bot_y) cy_d = bot_y;
  end

  // Full-width squares of the differences.
  logic signed [45:0] sq_dx, sq_dy;
  assign sq_dx = dx_q * dx_q;
  assign sq_dy = dy_q * dy_q;

  // Square root unit, two bits of the radicand per cycle.
  logic [31:0] sq_n_q;
  logic [17:0] sq_rem_q;
  logic [15:0] root_q;
  logic [4:0]  sq_cnt_q;
  logic [19:0] sq_w, sq_t;
  assign sq_w = {sq_rem_q, sq_n_q[31:30]};
  assign sq_t = {2'd0, root_q, 2'b01};

  // Two divider lanes for the normal, one quotient bit per cycle.
  logic [32:0] dv_n_q [2];
  logic [15:0] dv_r_q [2];
  logic [16:0] dv_q_q [2];
  logic        dv_neg_q [2];
  logic [5:0]  dv_cnt_q;
  logic [16:0] dv_w [2];
  logic signed [17:0] nrm [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dv_w[l] = {dv_r_q[l], dv_n_q[l][32]};
      // The quotient never exceeds one in Q.16, so no clamp is needed.
      nrm[l]  = dv_neg_q[l] ? -signed'({1'b0, dv_q_q[l]}) : signed'({1'b0, dv_q_q[l]});
    end
  end

  logic signed [35:0] mpx_q, mpy_q;
  logic signed [37:0] pvx_q, pvy_q;
  logic signed [23:0] dot_q;
  logic signed [39:0] qx_q, qy_q;
  logic signed [22:0] adx, ady;
  assign adx = dx_q[22] ? -dx_q : dx_q;
  assign ady = dy_q[22] ? -dy_q : dy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[addr_i] <= {box_x_i, box_y_i, box_w_i, box_h_i};
    end
    if (cmd_i.mem_re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= cbr_pkg::RADIUS_RESET;
      sq_cnt_q <= '0;
      dv_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      if (cmd_i.sqrt_start) begin
        sq_cnt_q <= 5'(cbr_pkg::SQRT_STEPS);
      end else if (sq_cnt_q != '0) begin
        sq_cnt_q <= sq_cnt_q - 5'd1;
      end
      if (cmd_i.div_start) begin
        dv_cnt_q <= 6'(cbr_pkg::DIV_STEPS);
      end else if (dv_cnt_q != '0) begin
        dv_cnt_q <= dv_cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      vx_q   <= vel_x_i;
      vy_q   <= vel_y_i;
      surf_q <= 1'b0;
    end
    if (cmd_i.clamp) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      dx_q <= 23'(px_q) - cx_d;
      dy_q <= 23'(py_q) - cy_d;
    end
    if (cmd_i.square) begin
      d2_q <= 45'(unsigned'(sq_dx)) + 45'(unsigned'(sq_dy));
      r2_q <= 32'(rq * rq);
    end
    if (cmd_i.sqrt_start) begin
      sq_n_q   <= d2_q[31:0];
      sq_rem_q <= '0;
      root_q   <= '0;
    end else if (sq_cnt_q != '0) begin
      sq_n_q <= {sq_n_q[29:0], 2'b00};
      if (sq_w >= sq_t) begin
        sq_rem_q <= 18'(sq_w - sq_t);
        root_q   <= {root_q[14:0], 1'b1};
      end else begin
        sq_rem_q <= sq_w[17:0];
        root_q   <= {root_q[14:0], 1'b0};
      end
    end
    if (cmd_i.div_start) begin
      dv_n_q[0]   <= {adx[16:0], 16'd0};
      dv_n_q[1]   <= {ady[16:0], 16'd0};
      dv_neg_q[0] <= dx_q[22];
      dv_neg_q[1] <= dy_q[22];
      for (int l = 0; l < 2; l++) begin
        dv_r_q[l] <= '0;
        dv_q_q[l] <= '0;
      end
    end else if (dv_cnt_q != '0) begin
      for (int l = 0; l < 2; l++) begin
        dv_n_q[l] <= {dv_n_q[l][31:0], 1'b0};
        if (dv_w[l] >= {1'b0, root_q}) begin
          dv_r_q[l] <= 16'(dv_w[l] - {1'b0, root_q});
          dv_q_q[l] <= {dv_q_q[l][15:0], 1'b1};
        end else begin
          dv_r_q[l] <= dv_w[l][15:0];
          dv_q_q[l] <= {dv_q_q[l][15:0], 1'b0};
        end
      end
    end
    if (cmd_i.mul_a) begin
      mpx_q <= nrm[0] * signed'({1'b0, rq});
      mpy_q <= nrm[1] * signed'({1'b0, rq});
      pvx_q <= vx_q * nrm[0];
      pvy_q <= vy_q * nrm[1];
    end
    if (cmd_i.upd_b) begin
      px_q  <= cbr_pkg::sat20(24'(cx_q) + cbr_pkg::rnd16(40'(mpx_q)));
      py_q  <= cbr_pkg::sat20(24'(cy_q) + cbr_pkg::rnd16(40'(mpy_q)));
      dot_q <= cbr_pkg::rnd16(40'(pvx_q) + 40'(pvy_q));
      if (nrm[1] < -18'sd32768) begin
        surf_q <= 1'b1;
      end
    end
    if (cmd_i.mul_c) begin
      qx_q <= nrm[0] * dot_q;
      qy_q <= nrm[1] * dot_q;
    end
    if (cmd_i.upd_d && dot_q[23]) begin
      vx_q <= cbr_pkg::sat20(24'(vx_q) - cbr_pkg::rnd16(qx_q));
      vy_q <= cbr_pkg::sat20(24'(vy_q) - cbr_pkg::rnd16(qy_q));
    end
    if (cmd_i.out_load) begin
      new_pos_x_o  <= px_q;
      new_pos_y_o  <= py_q;
      new_vel_x_o  <= vx_q;
      new_vel_y_o  <= vy_q;
      on_surface_o <= surf_q;
    end
  end

  assign sts_o.contact   = (d2_q != '0) && (d2_q <= {13'd0, r2_q});
  assign sts_o.sqrt_done = (sq_cnt_q == '0);
  assign sts_o.div_done  = (dv_cnt_q == '0);

endmodule

// ===== hdl/cbr_controller.sv =====
module cbr_controller #(
  parameter int unsigned MAX_BOXES = 256,
  parameter int unsigned AW        = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
  parameter int unsigned CW        = $clog2(MAX_BOXES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_cmd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cbr_pkg::cbr_cmd_t cmd_o,
  input  cbr_pkg::cbr_sts_t sts_i,
  output logic [AW-1:0]     addr_o
);

  cbr_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, idx_q, idx_d, idx_nx;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbr_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign idx_nx = idx_q + CW'(1);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    addr_o     = idx_q[AW-1:0];
    case (state_q)
      cbr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        addr_o     = count_q[AW-1:0];
        if (in_valid_i) begin
          case (in_cmd_i)
            cbr_pkg::CMD_CLEAR: begin
              count_d = '0;
            end
            cbr_pkg::CMD_APPEND: begin
              if (count_q < CW'(MAX_BOXES)) begin
                cmd_o.mem_we = 1'b1;
                count_d      = count_q + CW'(1);
              end
            end
            cbr_pkg::CMD_RESOLVE: begin
              cmd_o.load_in = 1'b1;
              idx_d         = '0;
              state_d       = (count_q == '0) ? cbr_pkg::ST_FIN : cbr_pkg::ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      cbr_pkg::ST_READ: begin
        cmd_o.mem_re = 1'b1;
        state_d      = cbr_pkg::ST_CLAMP;
      end
      cbr_pkg::ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = cbr_pkg::ST_SQUARE;
      end
      cbr_pkg::ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = cbr_pkg::ST_TEST;
      end
      cbr_pkg::ST_TEST: begin
        if (sts_i.contact) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = cbr_pkg::ST_SQRT;
        end else if (idx_nx == count_q) begin
          state_d = cbr_pkg::ST_FIN;
        end else begin
          idx_d   = idx_nx;
          state_d = cbr_pkg::ST_READ;
        end
      end
      cbr_pkg::ST_SQRT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = cbr_pkg::ST_DIV;
        end
      end
      cbr_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = cbr_pkg::ST_MULA;
        end
      end
      cbr_pkg::ST_MULA: begin
        cmd_o.mul_a = 1'b1;
        state_d     = cbr_pkg::ST_UPDB;
      end
      cbr_pkg::ST_UPDB: begin
        cmd_o.upd_b = 1'b1;
        state_d     = cbr_pkg::ST_MULC;
      end
      cbr_pkg::ST_MULC: begin
        cmd_o.mul_c = 1'b1;
        state_d     = cbr_pkg::ST_UPDD;
      end
      cbr_pkg::ST_UPDD: begin
        cmd_o.upd_d = 1'b1;
        if (idx_nx == count_q) begin
          state_d = cbr_pkg::ST_FIN;
        end else begin
          idx_d   = idx_nx;
          state_d = cbr_pkg::ST_READ;
        end
      end
      cbr_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = cbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cbr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/circle_box_collision_resolver_core.sv =====
// Channel   Direction  Contents
// in_i      sink       command, box_x/y/width/height, pos_x/y, vel_x/y
// out_o     source     new_pos_x/y, new_vel_x/y, on_surface
// cfg       write      circle_radius (cfg_we_i, cfg_wdata_i)
//
// A resolve walks the box table; a box in contact also passes through the
// 16-step square root and the 33-step normal dividers. Reset empties the
// box table and sets the radius to 25. The result sits in its own output
// register, so a new transaction is taken while the last result waits; a
// resolve that finishes before that result is taken waits in its final
// state.

module circle_box_collision_resolver_core #(
  parameter int unsigned MAX_BOXES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  cbr_in_if.sink      in_i,
  cbr_out_if.source   out_o
);

  localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);

  cbr_pkg::cbr_cmd_t cmd;
  cbr_pkg::cbr_sts_t sts;
  logic [AW-1:0]     addr;

  // The controller owns the box count, the table walk and the handshakes.
  cbr_controller #(
    .MAX_BOXES (MAX_BOXES),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.command),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .addr_o      (addr)
  );

  // The datapath holds the box memory, the radius register, the circle
  // state and the arithmetic units.
  cbr_datapath #(
    .MAX_BOXES (MAX_BOXES),
    .AW        (AW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .addr_i       (addr),
    .box_x_i      (in_i.box_x),
    .box_y_i      (in_i.box_y),
    .box_w_i      (in_i.box_width),
    .box_h_i      (in_i.box_height),
    .pos_x_i      (in_i.pos_x),
    .pos_y_i      (in_i.pos_y),
    .vel_x_i      (in_i.vel_x),
    .vel_y_i      (in_i.vel_y),
    .new_pos_x_o  (out_o.new_pos_x),
    .new_pos_y_o  (out_o.new_pos_y),
    .new_vel_x_o  (out_o.new_vel_x),
    .new_vel_y_o  (out_o.new_vel_y),
    .on_surface_o (out_o.on_surface)
  );

endmodule
